>>> design/gql_pkg.sv
// ----------------------------------------------------------------------------
// gql_pkg: shared types and constants for the glyph quad layout block
// Work item format between front end and back end, configuration bundle,
// character codes and the saturating position adder.
// ----------------------------------------------------------------------------
package gql_pkg;

   // Work queue geometry
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Character codes with special meaning
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_START_X      = 3'd0;
   localparam logic [2:0] REG_START_Y      = 3'd1;
   localparam logic [2:0] REG_SCALE        = 3'd2;
   localparam logic [2:0] REG_CHAR_SPACING = 3'd3;
   localparam logic [2:0] REG_LINE_HEIGHT  = 3'd4;
   localparam logic [2:0] REG_BASELINE     = 3'd5;
   localparam logic [2:0] REG_MAX_QUADS    = 3'd6;

   // Quad corner codes
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_BL = 2'd1;
   localparam logic [1:0] CORNER_BR = 2'd2;
   localparam logic [1:0] CORNER_TR = 2'd3;

   // Position limits, signed 16.8
   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] POS_MIN = 24'sh800000;
   localparam logic signed [27:0] SUM_MAX = 28'sd8388607;
   localparam logic signed [27:0] SUM_MIN = -28'sd8388608;

   typedef enum logic [1:0] {
      KIND_ADVANCE,
      KIND_NEWLINE,
      KIND_DRAW
   } kind_type;

   // Classified character with its scaled metrics
   typedef struct packed {
      logic               first;
      kind_type           kind;
      logic [15:0]        left_u;
      logic [15:0]        right_u;
      logic [15:0]        top_v;
      logic [15:0]        bottom_v;
      logic signed [26:0] xo_p;
      logic signed [26:0] yo_p;
      logic signed [26:0] h_p;
      logic signed [26:0] w_p;
      logic signed [26:0] step_p;
   } work_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   typedef struct packed {
      logic signed [23:0] start_x;
      logic signed [23:0] start_y;
      logic [15:0]        scale;
      logic signed [15:0] char_spacing;
      logic [7:0]         line_height;
      logic [7:0]         baseline;
      logic [14:0]        max_quads;
   } cfg_type;

   // Clamp a widened sum to the signed 24-bit position range
   function automatic logic signed [23:0] sat_pos(input logic signed [27:0] v);
      logic signed [23:0] r;
      if (v > SUM_MAX) begin
         r = POS_MAX;
      end else if (v < SUM_MIN) begin
         r = POS_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   // Position plus a scaled offset, saturated
   function automatic logic signed [23:0] add_pos(input logic signed [23:0] p,
                                                  input logic signed [26:0] d);
      logic signed [27:0] s;
      s = 28'(p) + 28'(d);
      return sat_pos(s);
   endfunction

endpackage

>>> design/gql_front.sv
// ----------------------------------------------------------------------------
// gql_front: glyph table and character classifier
// Writes glyph entries on load items, reads the entry of each character,
// scales its metrics and pushes one classified item into the work queue.
// ----------------------------------------------------------------------------
module gql_front #(
   parameter int GLYPHS = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_type,
   input  logic [7:0]          req_char_code,
   input  logic                req_first_of_string,
   input  logic [15:0]         req_left_u,
   input  logic [15:0]         req_right_u,
   input  logic [15:0]         req_top_v,
   input  logic [15:0]         req_bottom_v,
   input  logic [7:0]          req_glyph_width,
   input  logic [7:0]          req_glyph_height,
   input  logic signed [7:0]   req_x_offset,
   input  logic signed [7:0]   req_y_offset,
   input  logic [7:0]          req_x_advance,
   input  gql_pkg::cfg_type    cfg,
   input  gql_pkg::qstat_type  qstat,
   output logic                push,
   output gql_pkg::work_type   push_data
);

   localparam int MEM_D = (GLYPHS < 256) ? GLYPHS : 256;
   localparam int IDX_W = $clog2(MEM_D);
   localparam int QCNT_W_P = gql_pkg::QCNT_W;

   typedef struct packed {
      logic [15:0] left_u;
      logic [15:0] right_u;
      logic [15:0] top_v;
      logic [15:0] bottom_v;
   } tex_type;

   typedef struct packed {
      logic [7:0]        width;
      logic [7:0]        height;
      logic signed [7:0] x_offset;
      logic signed [7:0] y_offset;
      logic [7:0]        x_advance;
   } met_type;

   tex_type            tex_mem [MEM_D];
   met_type            met_mem [MEM_D];
   logic [MEM_D-1:0]   valid_ff;
   logic [7:0]         space_adv_ff;

   logic               a_valid_ff;
   logic               a_first_ff;
   logic               a_hit_ff;
   logic [7:0]         a_code_ff;
   logic [7:0]         a_space_adv_ff;
   tex_type            a_tex_ff;
   met_type            a_met_ff;

   logic               accept;
   logic               in_range;
   logic [IDX_W-1:0]   addr;
   logic               is_load;
   logic [QCNT_W_P:0]  pending;

   tex_type            tex;
   met_type            met;
   logic [8:0]         adv_sel;
   logic signed [16:0] scale_s;
   logic signed [24:0] xo_prod;
   logic signed [24:0] yo_prod;
   logic [23:0]        h_prod;
   logic [23:0]        w_prod;
   logic [24:0]        adv_prod;

   // Hold off while queued plus in-flight items fill the work queue
   assign pending  = {1'b0, qstat.count} + {QCNT_W_P'(0), a_valid_ff};
   assign req_full = (pending >= (QCNT_W_P + 1)'(gql_pkg::QDEPTH));
   assign accept   = req_push & ~req_full;
   assign is_load  = ~req_type;
   assign in_range = (32'(req_char_code) < GLYPHS);
   assign addr     = req_char_code[IDX_W-1:0];

   // Glyph table: write on load, registered read on character
   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         tex_mem[addr] <= '{req_left_u, req_right_u, req_top_v, req_bottom_v};
         met_mem[addr] <= '{req_glyph_width, req_glyph_height, req_x_offset,
                            req_y_offset, req_x_advance};
      end
      if (accept && !is_load) begin
         a_tex_ff       <= tex_mem[addr];
         a_met_ff       <= met_mem[addr];
         a_hit_ff       <= in_range && valid_ff[addr];
         a_code_ff      <= req_char_code;
         a_first_ff     <= req_first_of_string;
         a_space_adv_ff <= space_adv_ff;
      end
   end

   // Track written entries and the space advance used by zero-advance tabs
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         space_adv_ff <= '0;
         a_valid_ff   <= 1'b0;
      end else begin
         a_valid_ff <= accept && !is_load;
         if (accept && is_load && in_range) begin
            valid_ff[addr] <= 1'b1;
            if (req_char_code == gql_pkg::CODE_SPACE) begin
               space_adv_ff <= req_x_advance;
            end
         end
      end
   end

   // Unwritten or out-of-range entries read as zero
   assign tex = a_hit_ff ? a_tex_ff : '0;
   assign met = a_hit_ff ? a_met_ff : '0;

   // Pick the advance: a tab with no advance takes two spaces
   always_comb begin
      if (a_code_ff == gql_pkg::CODE_TAB && met.x_advance == 8'd0) begin
         adv_sel = {a_space_adv_ff, 1'b0};
      end else begin
         adv_sel = {1'b0, met.x_advance};
      end
   end

   // Scale metrics, one multiplier per field
   assign scale_s  = {1'b0, cfg.scale};
   assign xo_prod  = met.x_offset * scale_s;
   assign yo_prod  = met.y_offset * scale_s;
   assign h_prod   = met.height * cfg.scale;
   assign w_prod   = met.width * cfg.scale;
   assign adv_prod = adv_sel * cfg.scale;

   // Classify and build the work item
   always_comb begin
      push_data          = '0;
      push_data.first    = a_first_ff;
      push_data.left_u   = tex.left_u;
      push_data.right_u  = tex.right_u;
      push_data.top_v    = tex.top_v;
      push_data.bottom_v = tex.bottom_v;
      push_data.xo_p     = 27'(xo_prod);
      push_data.yo_p     = 27'(yo_prod);
      push_data.h_p      = $signed({3'b000, h_prod});
      push_data.w_p      = $signed({3'b000, w_prod});
      push_data.step_p   = $signed({2'b00, adv_prod}) + 27'(cfg.char_spacing);
      priority if (a_code_ff == gql_pkg::CODE_NEWLINE) begin
         push_data.kind = gql_pkg::KIND_NEWLINE;
      end else if (a_code_ff != gql_pkg::CODE_SPACE && a_code_ff != gql_pkg::CODE_TAB
                   && met.width != 8'd0) begin
         push_data.kind = gql_pkg::KIND_DRAW;
      end else begin
         push_data.kind = gql_pkg::KIND_ADVANCE;
      end
   end

   assign push = a_valid_ff;

endmodule

>>> design/gql_queue.sv
// ----------------------------------------------------------------------------
// gql_queue: work queue between classifier and layout engine
// Small circular buffer; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module gql_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gql_pkg::work_type  push_data,
   input  logic               pop,
   output gql_pkg::work_type  head,
   output gql_pkg::qstat_type qstat
);

   localparam int QPTR_W = gql_pkg::QPTR_W;
   localparam int QCNT_W = gql_pkg::QCNT_W;

   gql_pkg::work_type   q_mem [gql_pkg::QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head        = q_mem[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.count = count_ff;

endmodule

>>> design/gql_back.sv
// ----------------------------------------------------------------------------
// gql_back: layout engine
// Owns the pen, quad count and stop flag; walks each drawable character
// through its four corners and buffers vertices for the result side.
// ----------------------------------------------------------------------------
module gql_back (
   input  logic               clock,
   input  logic               reset,
   input  gql_pkg::cfg_type   cfg,
   input  gql_pkg::work_type  head,
   input  gql_pkg::qstat_type qstat,
   output logic               pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [23:0] rsp_vertex_x,
   output logic signed [23:0] rsp_vertex_y,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [1:0]         rsp_corner,
   output logic               rsp_last_of_quad
);

   typedef enum logic [1:0] {
      S_HEAD,
      S_V1,
      S_V2,
      S_V3
   } state_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [15:0]        u;
      logic [15:0]        v;
      logic [1:0]         corner;
      logic               last;
   } vert_type;

   state_type          state_ff, state_in;
   logic signed [23:0] pen_x_ff, pen_x_in;
   logic signed [23:0] pen_y_ff, pen_y_in;
   logic [14:0]        count_ff, count_in;
   logic               stopped_ff, stopped_in;
   logic signed [23:0] x0_ff, x0_in;
   logic signed [23:0] y0_ff, y0_in;
   logic signed [23:0] y1_ff, y1_in;
   logic signed [23:0] x2_ff, x2_in;

   logic [23:0]        base_p_ff;
   logic [23:0]        line_p_ff;
   logic signed [23:0] start_py_ff;

   logic signed [23:0] eff_x;
   logic signed [23:0] eff_y;
   logic [14:0]        eff_count;
   logic               eff_stopped;
   logic signed [23:0] x0_c;
   logic signed [23:0] y0_c;
   logic signed [23:0] y1_c;
   logic signed [23:0] x2_c;
   logic [14:0]        count_next;
   logic [14:0]        limit;

   vert_type           obuf [2];
   logic [1:0]         ocount_ff;
   logic               owr_ff;
   logic               ord_ff;
   logic               o_room;
   logic               o_pop;
   logic               v_we;
   vert_type           vtx;

   // Config-derived products; user must let them settle before items arrive
   always_ff @(posedge clock) begin
      base_p_ff   <= cfg.baseline * cfg.scale;
      line_p_ff   <= cfg.line_height * cfg.scale;
      start_py_ff <= gql_pkg::sat_pos(28'(cfg.start_y) - $signed({4'b0000, base_p_ff}));
   end

   // Pen as seen by the head item: the start of a string resets it
   always_comb begin
      eff_x       = head.first ? cfg.start_x : pen_x_ff;
      eff_y       = head.first ? start_py_ff : pen_y_ff;
      eff_count   = head.first ? 15'd0 : count_ff;
      eff_stopped = head.first ? 1'b0 : stopped_ff;
      x0_c        = gql_pkg::add_pos(eff_x, head.xo_p);
      y0_c        = gql_pkg::add_pos(eff_y, head.yo_p);
      y1_c        = gql_pkg::add_pos(y0_ff, head.h_p);
      x2_c        = gql_pkg::add_pos(x0_ff, head.w_p);
      count_next  = count_ff + 15'd1;
      limit       = (cfg.max_quads == 15'd0) ? 15'd1 : cfg.max_quads;
   end

   assign o_pop  = rsp_pop && (ocount_ff != 2'd0);
   assign o_room = (ocount_ff != 2'd2);

   // Sequence items and corners
   always_comb begin
      state_in   = state_ff;
      pen_x_in   = pen_x_ff;
      pen_y_in   = pen_y_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      x0_in      = x0_ff;
      y0_in      = y0_ff;
      y1_in      = y1_ff;
      x2_in      = x2_ff;
      pop        = 1'b0;
      v_we       = 1'b0;
      vtx        = '0;
      unique case (state_ff)
         S_HEAD: begin
            if (!qstat.empty) begin
               priority if (eff_stopped) begin
                  pop        = 1'b1;
                  pen_x_in   = eff_x;
                  pen_y_in   = eff_y;
                  count_in   = eff_count;
                  stopped_in = eff_stopped;
               end else if (head.kind == gql_pkg::KIND_NEWLINE) begin
                  pop        = 1'b1;
                  pen_x_in   = cfg.start_x;
                  pen_y_in   = gql_pkg::add_pos(eff_y, $signed({3'b000, line_p_ff}));
                  count_in   = eff_count;
                  stopped_in = eff_stopped;
               end else if (head.kind == gql_pkg::KIND_DRAW) begin
                  if (o_room) begin
                     v_we       = 1'b1;
                     vtx        = '{x0_c, y0_c, head.left_u, head.top_v,
                                    gql_pkg::CORNER_TL, 1'b0};
                     x0_in      = x0_c;
                     y0_in      = y0_c;
                     pen_x_in   = eff_x;
                     pen_y_in   = eff_y;
                     count_in   = eff_count;
                     stopped_in = eff_stopped;
                     state_in   = S_V1;
                  end
               end else begin
                  pop        = 1'b1;
                  pen_x_in   = gql_pkg::add_pos(eff_x, head.step_p);
                  pen_y_in   = eff_y;
                  count_in   = eff_count;
                  stopped_in = eff_stopped;
               end
            end
         end
         S_V1: begin
            if (o_room) begin
               v_we     = 1'b1;
               vtx      = '{x0_ff, y1_c, head.left_u, head.bottom_v,
                            gql_pkg::CORNER_BL, 1'b0};
               y1_in    = y1_c;
               state_in = S_V2;
            end
         end
         S_V2: begin
            if (o_room) begin
               v_we     = 1'b1;
               vtx      = '{x2_c, y1_ff, head.right_u, head.bottom_v,
                            gql_pkg::CORNER_BR, 1'b0};
               x2_in    = x2_c;
               state_in = S_V3;
            end
         end
         S_V3: begin
            if (o_room) begin
               v_we     = 1'b1;
               vtx      = '{x2_ff, y0_ff, head.right_u, head.top_v,
                            gql_pkg::CORNER_TR, 1'b1};
               pop      = 1'b1;
               count_in = count_next;
               if (count_next >= limit) begin
                  stopped_in = 1'b1;
               end else begin
                  pen_x_in = gql_pkg::add_pos(pen_x_ff, head.step_p);
               end
               state_in = S_HEAD;
            end
         end
         default: begin
            state_in = S_HEAD;
         end
      endcase
   end

   // Hold layout state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_HEAD;
         pen_x_ff   <= '0;
         pen_y_ff   <= '0;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pen_x_ff   <= pen_x_in;
         pen_y_ff   <= pen_y_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      x2_ff <= x2_in;
   end

   // Two-entry vertex buffer on the result side
   always_ff @(posedge clock) begin
      if (reset) begin
         ocount_ff <= '0;
         owr_ff    <= 1'b0;
         ord_ff    <= 1'b0;
      end else begin
         ocount_ff <= ocount_ff + 2'(v_we) - 2'(o_pop);
         if (v_we) begin
            owr_ff <= ~owr_ff;
         end
         if (o_pop) begin
            ord_ff <= ~ord_ff;
         end
      end
      if (v_we) begin
         obuf[owr_ff] <= vtx;
      end
   end

   assign rsp_empty        = (ocount_ff == 2'd0);
   assign rsp_vertex_x     = obuf[ord_ff].x;
   assign rsp_vertex_y     = obuf[ord_ff].y;
   assign rsp_tex_u        = obuf[ord_ff].u;
   assign rsp_tex_v        = obuf[ord_ff].v;
   assign rsp_corner       = obuf[ord_ff].corner;
   assign rsp_last_of_quad = obuf[ord_ff].last;

endmodule

>>> design/glyph_quad_layout.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout: bitmap font text layout
// Loads glyph entries and turns character codes into textured quads,
// four vertices per drawable character, positions in signed 16.8.
//
//   Channel   Ports                        Moves
//   req       req_push / req_full          one load or character item
//   rsp       rsp_pop / rsp_empty          one quad vertex
//   csr       csr_we, csr_index, csr_wdata one register write
//
// A drawable character leaves the layout engine one vertex per state, each
// waiting while the vertex buffer is full; newlines, spaces, tabs and
// undrawable codes are consumed in the head state; loads are written into
// the glyph table on the cycle they are accepted. A first vertex passes
// classifier, queue and vertex buffer registers. Reset is synchronous;
// glyph entries read as zero until loaded, through per-entry valid bits,
// so there is no clearing pass. rsp_pop low holds vertices; up to 4 work
// items and 2 vertices are buffered before req_full rises.
// ----------------------------------------------------------------------------
module glyph_quad_layout #(
   parameter int GLYPHS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_type,
   input  logic [7:0]         req_char_code,
   input  logic               req_first_of_string,
   input  logic [15:0]        req_left_u,
   input  logic [15:0]        req_right_u,
   input  logic [15:0]        req_top_v,
   input  logic [15:0]        req_bottom_v,
   input  logic [7:0]         req_glyph_width,
   input  logic [7:0]         req_glyph_height,
   input  logic signed [7:0]  req_x_offset,
   input  logic signed [7:0]  req_y_offset,
   input  logic [7:0]         req_x_advance,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [23:0] rsp_vertex_x,
   output logic signed [23:0] rsp_vertex_y,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [1:0]         rsp_corner,
   output logic               rsp_last_of_quad,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   gql_pkg::cfg_type   cfg_ff;
   gql_pkg::work_type  push_data;
   gql_pkg::work_type  head;
   gql_pkg::qstat_type qstat;
   logic               push;
   logic               pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x      <= '0;
         cfg_ff.start_y      <= '0;
         cfg_ff.scale        <= 16'd256;
         cfg_ff.char_spacing <= '0;
         cfg_ff.line_height  <= '0;
         cfg_ff.baseline     <= '0;
         cfg_ff.max_quads    <= 15'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            gql_pkg::REG_START_X:      cfg_ff.start_x      <= csr_wdata;
            gql_pkg::REG_START_Y:      cfg_ff.start_y      <= csr_wdata;
            gql_pkg::REG_SCALE:        cfg_ff.scale        <= csr_wdata[15:0];
            gql_pkg::REG_CHAR_SPACING: cfg_ff.char_spacing <= csr_wdata[15:0];
            gql_pkg::REG_LINE_HEIGHT:  cfg_ff.line_height  <= csr_wdata[7:0];
            gql_pkg::REG_BASELINE:     cfg_ff.baseline     <= csr_wdata[7:0];
            gql_pkg::REG_MAX_QUADS:    cfg_ff.max_quads    <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   gql_front #(
      .GLYPHS(GLYPHS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_type           (req_type),
      .req_char_code      (req_char_code),
      .req_first_of_string(req_first_of_string),
      .req_left_u         (req_left_u),
      .req_right_u        (req_right_u),
      .req_top_v          (req_top_v),
      .req_bottom_v       (req_bottom_v),
      .req_glyph_width    (req_glyph_width),
      .req_glyph_height   (req_glyph_height),
      .req_x_offset       (req_x_offset),
      .req_y_offset       (req_y_offset),
      .req_x_advance      (req_x_advance),
      .cfg                (cfg_ff),
      .qstat              (qstat),
      .push               (push),
      .push_data          (push_data)
   );

   gql_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   gql_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .qstat           (qstat),
      .pop             (pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_corner      (rsp_corner),
      .rsp_last_of_quad(rsp_last_of_quad)
   );

endmodule

>>> design/gql_checker.sv
// ----------------------------------------------------------------------------
// gql_checker: port-level checks for the glyph quad layout block
// Checks reset state, corner order, vertex hold and the shared left edge.
// ----------------------------------------------------------------------------
module gql_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [23:0] rsp_vertex_x,
   input logic [15:0]        rsp_tex_u,
   input logic [1:0]         rsp_corner,
   input logic               rsp_last_of_quad
);

   logic [1:0]         exp_corner_ff;
   logic signed [23:0] tl_x_ff;
   logic [15:0]        tl_u_ff;
   logic               taken;

   assign taken = rsp_pop && !rsp_empty;

   // Track the expected corner and the top-left vertex of each quad
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_corner_ff <= gql_pkg::CORNER_TL;
      end else if (taken) begin
         exp_corner_ff <= rsp_last_of_quad ? gql_pkg::CORNER_TL : rsp_corner + 2'd1;
      end
      if (taken && rsp_corner == gql_pkg::CORNER_TL) begin
         tl_x_ff <= rsp_vertex_x;
         tl_u_ff <= rsp_tex_u;
      end
   end

   a_reset_clean: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result side not empty or input full after reset");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_corner == exp_corner_ff
                     && rsp_last_of_quad == (rsp_corner == gql_pkg::CORNER_TR))
      else $error("vertex corner out of order");

   a_left_edge: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_corner == gql_pkg::CORNER_BL)
         |-> rsp_vertex_x == tl_x_ff && rsp_tex_u == tl_u_ff)
      else $error("bottom-left vertex does not share the left edge");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_vertex_x)
                                   && $stable(rsp_corner))
      else $error("waiting vertex changed");

endmodule

bind glyph_quad_layout gql_checker u_gql_checker (.*);
